// ===== sv/http_request_header_tokenizer_top_defines.svh =====
// Assertion macros shared by the tokenizer modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_TOP_DEFINES_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTOK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tokenizer same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HTOK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tokenizer next-cycle check failed");

`endif

// ===== sv/htok_pkg.sv =====
`default_nettype none

package htok_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URL     = 3'd1,
        PH_VERSION = 3'd2,
        PH_NAME    = 3'd3,
        PH_VALUE   = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    typedef enum logic [3:0] {
        EV_CONTENT  = 4'd0,
        EV_METHOD   = 4'd1,
        EV_URL      = 4'd2,
        EV_URLWORD  = 4'd3,
        EV_VERSION  = 4'd4,
        EV_NAME     = 4'd5,
        EV_SKIPPED  = 4'd6,
        EV_COLON    = 4'd7,
        EV_SPACE    = 4'd8,
        EV_VALUEEND = 4'd9,
        EV_DONE     = 4'd10,
        EV_ERROR    = 4'd11,
        EV_IGNORED  = 4'd12
    } t_event;

    typedef enum logic [1:0] {
        ST_PARSING = 2'd0,
        ST_DONE    = 2'd1,
        ST_ERROR   = 2'd2
    } t_status;

    // One accepted input item as held in the input register.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       stream_end;
    } t_item;

    // One result item as produced by the parser core.
    typedef struct packed {
        logic [7:0] data_byte;
        t_event     event_res;
        t_status    status;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/htok_in_if.sv =====
`default_nettype none

interface htok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       stream_end;

    modport source (output valid, output byte_value, output stream_end, input ready);
    modport sink (input valid, input byte_value, input stream_end, output ready);
endinterface

`default_nettype wire

// ===== sv/htok_out_if.sv =====
`default_nettype none

interface htok_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [3:0] event_res;
    logic [1:0] status;

    modport source (output valid, output data_byte, output event_res, output status,
                    input ready);
    modport sink (input valid, input data_byte, input event_res, input status,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/htok_in_stage.sv =====
`default_nettype none

module htok_in_stage
    import htok_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    htok_in_if.sink   i_in,
    input  logic      i_adv,
    output logic      o_valid,
    output t_item     o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_take;

    // The register can load whenever it is empty or its item moves on now.
    assign i_in.ready = !r_valid || i_adv;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.byte_value <= i_in.byte_value;
            r_item.stream_end <= i_in.stream_end;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== sv/htok_core.sv =====
`default_nettype none
`include "http_request_header_tokenizer_top_defines.svh"

module htok_core
    import htok_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    output t_result o_result
);

    t_phase  r_phase;
    t_phase  n_phase;
    logic    r_skip;
    logic    n_skip;
    t_event  w_event;
    logic    w_sp;
    logic    w_lf;
    logic    w_co;
    logic    w_sep;

    assign w_sp  = (i_item.byte_value == CH_SPACE);
    assign w_lf  = (i_item.byte_value == CH_LF);
    assign w_co  = (i_item.byte_value == CH_COLON);
    assign w_sep = i_item.byte_value inside {CH_SPACE, CH_LF, CH_COLON};

    always_comb begin
        n_phase = r_phase;
        n_skip  = r_skip;
        w_event = EV_CONTENT;
        case (r_phase)
            PH_METHOD, PH_URL, PH_VERSION, PH_NAME, PH_VALUE: begin
                if (i_item.stream_end) begin
                    w_event = EV_ERROR;
                    n_phase = PH_ERROR;
                    n_skip  = 1'b0;
                end else if (r_skip) begin
                    w_event = EV_SKIPPED;
                    n_skip  = 1'b0;
                end else if (!w_sep) begin
                    w_event = EV_CONTENT;
                end else begin
                    // Any separator not allowed in the phase lands in the error phase.
                    w_event = EV_ERROR;
                    n_phase = PH_ERROR;
                    case (r_phase)
                        PH_METHOD: begin
                            if (w_sp) begin
                                w_event = EV_METHOD;
                                n_phase = PH_URL;
                            end
                        end
                        PH_URL: begin
                            if (w_sp) begin
                                w_event = EV_URL;
                                n_phase = PH_VERSION;
                            end
                        end
                        PH_VERSION: begin
                            if (w_sp) begin
                                w_event = EV_URLWORD;
                                n_phase = PH_VERSION;
                            end else if (w_lf) begin
                                w_event = EV_VERSION;
                                n_phase = PH_NAME;
                            end
                        end
                        PH_NAME: begin
                            if (w_lf) begin
                                w_event = EV_DONE;
                                n_phase = PH_DONE;
                            end else if (w_co) begin
                                w_event = EV_NAME;
                                n_phase = PH_VALUE;
                                n_skip  = 1'b1;
                            end
                        end
                        default: begin
                            // Header value: every separator is legal here.
                            if (w_co) begin
                                w_event = EV_COLON;
                                n_phase = PH_VALUE;
                            end else if (w_sp) begin
                                w_event = EV_SPACE;
                                n_phase = PH_VALUE;
                            end else begin
                                w_event = EV_VALUEEND;
                                n_phase = PH_NAME;
                            end
                        end
                    endcase
                end
            end
            PH_DONE: begin
                w_event = EV_IGNORED;
            end
            default: begin
                // Error phase and the unused code both behave as error.
                w_event = EV_IGNORED;
                n_phase = PH_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD;
            r_skip  <= 1'b0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_skip  <= n_skip;
        end
    end

    always_comb begin
        o_result.data_byte = i_item.stream_end ? 8'h00 : i_item.byte_value;
        o_result.event_res = w_event;
        case (n_phase)
            PH_DONE:  o_result.status = ST_DONE;
            PH_ERROR: o_result.status = ST_ERROR;
            default:  o_result.status = ST_PARSING;
        endcase
    end

    // A pending skip only exists right after a header-name colon.
    `HTOK_ASSERT_NOW(a_skip_in_value, r_skip, r_phase == PH_VALUE)
    `HTOK_ASSERT_NEXT(a_done_sticky, r_phase == PH_DONE, r_phase == PH_DONE)
    `HTOK_ASSERT_NEXT(a_error_sticky, r_phase == PH_ERROR, r_phase == PH_ERROR)
    `HTOK_ASSERT_NOW(a_skip_event,
        i_adv && r_skip && !i_item.stream_end, o_result.event_res == EV_SKIPPED)

endmodule

`default_nettype wire

// ===== sv/http_request_header_tokenizer_top.sv =====
// Each item is taken into the input register, then moves on into the output register.
// Throughput: one item per cycle while the sink is ready; the input and output registers
// each accept a new item in the same cycle that their current item moves on.
// Reset (i_rst_n low at a clock edge): both registers empty, phase back to method, skip flag
// cleared; the block can accept items once reset is released.
`default_nettype none
`include "http_request_header_tokenizer_top_defines.svh"

module http_request_header_tokenizer_top
    import htok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    htok_in_if.sink    i_in,
    htok_out_if.source o_out
);

    // Input register: holds one accepted byte (or end-of-stream mark) so that the
    // parser logic sees a registered item and the input side never waits on
    // the output path more than one register deep.
    logic    w_in_valid;
    t_item   w_item;

    // The parser phase and skip flag advance exactly when the held item moves
    // into the output register, so every item is classified once.
    logic    w_adv;
    t_result w_result;

    // Output register: the finished result waits here for the sink.
    logic    r_out_valid;
    t_result r_out;

    assign w_adv = w_in_valid && (!r_out_valid || o_out.ready);

    htok_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (w_adv),
        .o_valid (w_in_valid),
        .o_item  (w_item)
    );

    htok_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (w_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.data_byte = r_out.data_byte;
    assign o_out.event_res = r_out.event_res;
    assign o_out.status    = r_out.status;

    // A held result must not be overwritten while the sink stalls.
    `HTOK_ASSERT_NOW(a_no_overwrite, r_out_valid && !o_out.ready, !w_adv)
    // An item that moves on always leaves a valid result behind.
    `HTOK_ASSERT_NEXT(a_adv_fills, w_adv, r_out_valid)
    // A done event is always reported with the done status.
    `HTOK_ASSERT_NOW(a_done_status,
        r_out_valid && r_out.event_res == EV_DONE, r_out.status == ST_DONE)

endmodule

`default_nettype wire
